FILE: rtl/sws_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and decode functions for the stopwatch scanner
// no dependencies
package sws_pkg;

  localparam int TICKS_PER_SECOND = 1000;
  localparam logic [9:0] MILLIS_LAST = 10'(TICKS_PER_SECOND - 1);
  localparam logic [5:0] SECONDS_LAST = 6'd59;
  localparam logic [5:0] MINUTES_LAST = 6'd59;

  localparam logic [7:0] CODE_F = 8'h46;
  localparam logic [7:0] CODE_B = 8'h42;
  localparam logic [7:0] CODE_L = 8'h4C;
  localparam logic [7:0] CODE_R = 8'h52;

  localparam logic [7:0] FONT_F = 8'h71;
  localparam logic [7:0] FONT_B = 8'h7C;
  localparam logic [7:0] FONT_L = 8'h38;
  localparam logic [7:0] FONT_R = 8'h50;
  localparam logic [7:0] FONT_S = 8'h6D;

  localparam logic [7:0] DECIMAL_POINT = 8'h80;

  typedef logic [1:0] sws_scan_t;

  typedef struct packed {
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [9:0] millis;
  } sws_time_t;

  typedef struct packed {
    logic [7:0] timer_segments;
    logic [3:0] timer_digit_enable_n;
    logic [3:0] status_nibble_high;
    logic [3:0] status_nibble_low;
    logic [3:0] status_digit_enable_n;
  } sws_display_t;

  typedef struct packed {
    sws_display_t display;
    sws_time_t    elapsed;
  } sws_result_t;

  function automatic logic [7:0] digit_font(input logic [3:0] d);
    logic [7:0] f;
    case (d)
      4'd0:    f = 8'h3F;
      4'd1:    f = 8'h06;
      4'd2:    f = 8'h5B;
      4'd3:    f = 8'h4F;
      4'd4:    f = 8'h66;
      4'd5:    f = 8'h6D;
      4'd6:    f = 8'h7D;
      4'd7:    f = 8'h27;
      4'd8:    f = 8'h7F;
      4'd9:    f = 8'h6F;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  // tens digit of a value below 60
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd50)      t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [2:0] t;
    logic [5:0] r;
    t = tens_of(v);
    r = v - ({t, 3'b000} + {2'b00, t, 1'b0});
    return r[3:0];
  endfunction

  function automatic logic [7:0] letter_pattern(input logic [7:0] code);
    logic [7:0] f;
    case (code)
      CODE_F:  f = FONT_F;
      CODE_B:  f = FONT_B;
      CODE_L:  f = FONT_L;
      CODE_R:  f = FONT_R;
      default: f = FONT_S;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] rev4(input logic [3:0] v);
    return {v[0], v[1], v[2], v[3]};
  endfunction

endpackage

FILE: rtl/sws_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for tick beats and display beats
// no dependencies
interface sws_tick_if;
  logic       valid;
  logic       ready;
  logic       run;
  logic [7:0] status_code;
  modport source(output valid, output run, output status_code, input ready);
  modport sink(input valid, input run, input status_code, output ready);
endinterface

interface sws_disp_if;
  logic       valid;
  logic       ready;
  logic [7:0] timer_segments;
  logic [3:0] timer_digit_enable_n;
  logic [3:0] status_nibble_high;
  logic [3:0] status_nibble_low;
  logic [3:0] status_digit_enable_n;
  logic [5:0] elapsed_minutes;
  logic [5:0] elapsed_seconds;
  logic [9:0] elapsed_millis;
  modport source(output valid, output timer_segments, output timer_digit_enable_n,
                 output status_nibble_high, output status_nibble_low,
                 output status_digit_enable_n, output elapsed_minutes,
                 output elapsed_seconds, output elapsed_millis, input ready);
  modport sink(input valid, input timer_segments, input timer_digit_enable_n,
               input status_nibble_high, input status_nibble_low,
               input status_digit_enable_n, input elapsed_minutes,
               input elapsed_seconds, input elapsed_millis, output ready);
endinterface

FILE: rtl/stopwatch_seven_segment_scanner_top.sv
`timescale 1ns / 1ps
// top level of the multiplexed seven-segment stopwatch scanner
// depends on sws_pkg, sws_if, sws_time_counter, sws_scan_display
//
// usage
//   tick: one beat per 1 ms tick, carrying run and an ascii status code
//   disp: one beat per tick with the segment pattern and one-cold enable of
//         the digit scanned on that tick (time before the tick's count), the
//         status letter F/b/L/r (S for any other code) as two bit-reversed
//         nibbles with its own enable, and the elapsed time after the count
// timing
//   a tick's beat is valid in the next cycle; a tick can be taken every cycle
//   unless a beat waits on disp.ready, the rate set by the single output register
// reset
//   rst (synchronous) clears the time to 00:00.000, the scan index to the
//   minutes-tens digit and drops the output valid
// stall
//   while a display beat waits, tick.ready follows disp.ready, so a new tick
//   is taken in the same cycle the waiting beat leaves; nothing is dropped
module stopwatch_seven_segment_scanner_top
  import sws_pkg::*;
(
  input logic     clk,
  input logic     rst,
  sws_tick_if.sink   tick,
  sws_disp_if.source disp
);

  logic         accept;
  logic         out_valid;
  sws_time_t    time_now;
  sws_time_t    time_next;
  sws_display_t display;
  sws_result_t  result;

  // output register empty or draining this cycle
  assign tick.ready = !out_valid || disp.ready;
  assign accept     = tick.valid && tick.ready;

  sws_time_counter u_time (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .run       (tick.run),
    .time_now  (time_now),
    .time_next (time_next)
  );

  sws_scan_display u_scan (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .time_now    (time_now),
    .status_code (tick.status_code),
    .display     (display)
  );

  // result register, valid flag is control and gets reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (disp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.display <= display;
      result.elapsed <= time_next;
    end
  end

  assign disp.valid                 = out_valid;
  assign disp.timer_segments        = result.display.timer_segments;
  assign disp.timer_digit_enable_n  = result.display.timer_digit_enable_n;
  assign disp.status_nibble_high    = result.display.status_nibble_high;
  assign disp.status_nibble_low     = result.display.status_nibble_low;
  assign disp.status_digit_enable_n = result.display.status_digit_enable_n;
  assign disp.elapsed_minutes       = result.elapsed.minutes;
  assign disp.elapsed_seconds       = result.elapsed.seconds;
  assign disp.elapsed_millis        = result.elapsed.millis;

endmodule

FILE: rtl/sws_time_counter.sv
`timescale 1ns / 1ps
// millisecond / second / minute counter with wrap after 59:59.999
// depends on sws_pkg
module sws_time_counter
  import sws_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  logic      run,
  output sws_time_t time_now,
  output sws_time_t time_next
);

  sws_time_t count;

  always_comb begin
    time_next = count;
    if (run) begin
      if (count.millis == MILLIS_LAST) begin
        time_next.millis = '0;
        if (count.seconds == SECONDS_LAST) begin
          time_next.seconds = '0;
          if (count.minutes == MINUTES_LAST) begin
            time_next.minutes = '0;
          end else begin
            time_next.minutes = count.minutes + 6'd1;
          end
        end else begin
          time_next.seconds = count.seconds + 6'd1;
        end
      end else begin
        time_next.millis = count.millis + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (advance) begin
      count <= time_next;
    end
  end

  assign time_now = count;

endmodule

FILE: rtl/sws_scan_display.sv
`timescale 1ns / 1ps
// scan index register and segment / digit-enable / status letter decode
// depends on sws_pkg
module sws_scan_display
  import sws_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  sws_time_t    time_now,
  input  logic [7:0]   status_code,
  output sws_display_t display
);

  sws_scan_t  scan_index;
  logic [7:0] font;

  always_comb begin
    case (scan_index)
      2'd0:    display.timer_segments = digit_font({1'b0, tens_of(time_now.minutes)});
      2'd1:    display.timer_segments = digit_font(units_of(time_now.minutes))
                                        | DECIMAL_POINT;
      2'd2:    display.timer_segments = digit_font({1'b0, tens_of(time_now.seconds)});
      default: display.timer_segments = digit_font(units_of(time_now.seconds));
    endcase
    display.timer_digit_enable_n  = ~(4'b0001 << scan_index);
    display.status_digit_enable_n = ~(4'b1000 >> scan_index);
    font                          = letter_pattern(status_code);
    display.status_nibble_high    = rev4(font[3:0]);
    display.status_nibble_low     = rev4(font[7:4]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index <= '0;
    end else if (advance) begin
      scan_index <= scan_index + 2'd1;
    end
  end

endmodule
